@@ rtl/sitd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_pkg
// Shared constants and controller/datapath interface types for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitd_pkg;

    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned MAX_DIGITS = 10;
    localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // ceil(2^35 / 10): exact quotient by ten for any 32-bit unsigned dividend
    localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
    } sitd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic emit_done;
    } sitd_status_t;

endpackage : sitd_pkg
`default_nettype wire

@@ rtl/signed_int_to_decimal_text_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_core
// Converts a signed 32-bit integer to its decimal ASCII text, most
// significant character first, with a leading minus sign when negative.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. The magnitude is
// then divided by ten once per cycle (a reciprocal multiply) until the
// quotient is zero, giving one decimal digit per divide (1 to 10 digits),
// after which the characters leave one per cycle on char_code, each marked
// by a one-cycle strobe, the sign first and last high on the final digit.
// The receiver cannot stall the output. The block stays busy through the
// divide and emission runs, and busy falls as the final character is
// presented, so the next transaction can be taken in that same cycle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text_core
    import sitd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] value,
    output logic                    strobe,
    output logic [7:0]              char_code,
    output logic                    last
);

    sitd_cmd_t    cmd;
    sitd_status_t status;

    sitd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sitd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (value),
        .status    (status),
        .strobe    (strobe),
        .char_code (char_code),
        .last      (last)
    );

    // a new transaction always passes through acceptance and the divide state before any output
    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("character strobe directly after final character");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transaction");

    // once idle, any character still shown must close the text
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && strobe |-> last)
        else $error("idle while text is incomplete");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (char_code == CHAR_MINUS) |-> !last)
        else $error("minus sign flagged as final character");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (char_code == CHAR_MINUS)
                || ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)))
        else $error("character outside sign and digit set");

endmodule : signed_int_to_decimal_text_core
`default_nettype wire

@@ rtl/sitd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_ctrl
// Sequencer: accepts a transaction, runs the divide-by-ten steps, then the
// character emission run.
// ----------------------------------------------------------------------------
module sitd_ctrl
    import sitd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire sitd_status_t status,
    output sitd_cmd_t         cmd,
    output logic              busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule : sitd_ctrl
`default_nettype wire

@@ rtl/sitd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sitd_datapath
// Magnitude register, reciprocal divide by ten, digit stack and the output
// character register.
// ----------------------------------------------------------------------------
module sitd_datapath
    import sitd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sitd_cmd_t           cmd,
    input  wire logic signed [31:0]  value,
    output sitd_status_t             status,
    output logic                     strobe,
    output logic [7:0]               char_code,
    output logic                     last
);

    logic [VALUE_W-1:0]   mag_reg;
    logic [3:0]           digit_reg [MAX_DIGITS];
    logic [CNT_W-1:0]     cnt_reg;
    logic                 sign_pending_reg;
    logic                 strobe_reg;
    logic [7:0]           char_reg;
    logic                 last_reg;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   rem_full;
    logic [3:0]           rem;
    logic [VALUE_W-1:0]   value_u;

    assign value_u  = value;
    assign prod     = {{VALUE_W{1'b0}}, mag_reg} * {{VALUE_W{1'b0}}, RECIP_TEN};
    assign quot     = {{RECIP_SHIFT - VALUE_W{1'b0}}, prod[2*VALUE_W-1:RECIP_SHIFT]};
    // remainder as mag - 8q - 2q
    assign rem_full = mag_reg - ((quot << 3) + (quot << 1));
    assign rem      = rem_full[3:0];

    assign status = '{
        div_done:  (quot == '0) || (cnt_reg == CNT_W'(MAX_DIGITS - 1)),
        emit_done: !sign_pending_reg && (cnt_reg == CNT_W'(1))
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            sign_pending_reg <= 1'b0;
            strobe_reg       <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.load)
            begin
                cnt_reg          <= '0;
                sign_pending_reg <= value_u[VALUE_W-1];
            end
            else if (cmd.div_step)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            else if (cmd.emit)
            begin
                if (sign_pending_reg)
                begin
                    sign_pending_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    // digit stack: top entry holds the most recently found (most significant) digit
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg <= value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;
        end
        else if (cmd.div_step)
        begin
            mag_reg      <= quot;
            digit_reg[0] <= rem;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                digit_reg[i] <= digit_reg[i-1];
            end
        end
        else if (cmd.emit && !sign_pending_reg)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                digit_reg[i] <= digit_reg[i+1];
            end
        end

        if (cmd.emit)
        begin
            if (sign_pending_reg)
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            else
            begin
                char_reg <= CHAR_ZERO + {4'h0, digit_reg[0]};
                last_reg <= (cnt_reg == CNT_W'(1));
            end
        end
    end

    assign strobe    = strobe_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

endmodule : sitd_datapath
`default_nettype wire
